@@ design/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// Types, constants and fixed-point helpers for the discrepancy correction term.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  // numerator magnitude: word magnitude shifted by up to FRAC_BITS + 1
  localparam int NUM_W     = WORD_W + FRAC_BITS + 2;
  localparam int WIDE_W    = 2 * WORD_W + 2;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] MAG_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] MAG_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [1:0] ACT_VALUE = 2'd0;
  localparam logic [1:0] ACT_GRAD  = 2'd1;
  localparam logic [1:0] ACT_HESS  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]               action;
    logic                     first_order_check;
    logic signed [WORD_W-1:0] truth_val;
    logic signed [WORD_W-1:0] approx_val;
    logic signed [WORD_W-1:0] truth_grad_row;
    logic signed [WORD_W-1:0] approx_grad_row;
    logic signed [WORD_W-1:0] truth_grad_col;
    logic signed [WORD_W-1:0] approx_grad_col;
    logic signed [WORD_W-1:0] truth_hess_entry;
    logic signed [WORD_W-1:0] approx_hess_entry;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     scale_warn;
    logic                     overflow;
  } result_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] v;
    logic                     o;
  } sat_t;

  typedef struct packed {
    logic neg_n;
    logic neg_d;
  } div_ctl_t;

  function automatic sat_t sat_word(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    r.o = 1'b0;
    r.v = x[WORD_W-1:0];
    if (x > WIDE_W'(WORD_MAX)) begin
      r.o = 1'b1;
      r.v = WORD_MAX;
    end else if (x < WIDE_W'(WORD_MIN)) begin
      r.o = 1'b1;
      r.v = WORD_MIN;
    end
    return r;
  endfunction

  // product / 2^FRAC_BITS, toward zero, saturated
  function automatic sat_t scale_q(input logic signed [2*WORD_W-1:0] p);
    logic signed [WIDE_W-1:0] b;
    b = WIDE_W'(p) + (p[2*WORD_W-1] ? WIDE_W'((64'd1 << FRAC_BITS) - 64'd1)
                                    : WIDE_W'(0));
    b = b >>> FRAC_BITS;
    return sat_word(b);
  endfunction

  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] x);
    return x[WORD_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ design/discrepancy_correction_term.sv @@
// ----------------------------------------------------------------------------
// discrepancy_correction_term
// One discrepancy term, additive or multiplicative, in signed Q16.16.
// Datapath: two 34-stage dividers lie between the item beat and the result register.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset: clears all valid bits; combine_mode 0, small_threshold 1.
// ----------------------------------------------------------------------------
module discrepancy_correction_term (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  dct_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output dct_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int W  = dct_pkg::WORD_W;
  localparam int NW = dct_pkg::NUM_W;
  localparam int XW = dct_pkg::WIDE_W;

  typedef struct packed {
    logic [1:0]          action;
    logic                mode;
    logic                bad;
    logic                ovf;
    logic signed [W-1:0] add_r;
    logic signed [W-1:0] a;
    logic signed [W-1:0] tgr;
    logic signed [W-1:0] agr;
    logic signed [W-1:0] agc;
    logic signed [2*W-1:0] asq_raw;
    logic signed [2*W-1:0] p1_raw;
    logic signed [2*W-1:0] p2_raw;
    logic signed [2*W-1:0] p4_raw;
    logic signed [2*W-1:0] p5_raw;
    logic [NW-1:0]       num;
    logic [W-1:0]        den;
    dct_pkg::div_ctl_t   ctl;
  } s2_t;

  typedef struct packed {
    logic [1:0]          action;
    logic                mode;
    logic                bad;
    logic                ovf;
    logic signed [W-1:0] add_r;
    logic signed [W-1:0] a;
    logic signed [W-1:0] tgr;
    logic signed [W-1:0] agr;
    logic signed [W-1:0] agc;
    logic signed [W-1:0] asq;
    logic signed [W-1:0] p1;
    logic signed [W-1:0] p2;
    logic signed [W-1:0] p4;
    logic signed [W-1:0] p5;
  } mid_t;

  typedef struct packed {
    logic [1:0]          action;
    logic                mode;
    logic                bad;
    logic                ovf;
    logic signed [W-1:0] add_r;
    logic signed [W-1:0] ratio;
    logic signed [W-1:0] a;
    logic signed [W-1:0] tgr;
    logic signed [W-1:0] agc;
    logic signed [W-1:0] asq;
    logic signed [W-1:0] p1;
    logic signed [W-1:0] p2;
    logic signed [W-1:0] p3;
    logic signed [W-1:0] p4;
    logic signed [W-1:0] p5;
    logic signed [W-1:0] m;
    logic signed [W-1:0] diff;
    logic signed [2*W-1:0] prod_raw;
  } tail_t;

  typedef struct packed {
    logic [1:0]          action;
    logic                mode;
    logic                bad;
    logic                ovf;
    logic signed [W-1:0] add_r;
    logic signed [W-1:0] ratio;
  } fin_t;

  logic          combine_mode;
  logic [W-2:0]  small_threshold;
  logic          en;

  logic           s1_valid, s2_valid, s4_valid, s5_valid, s6_valid, s7_valid, s8_valid;
  dct_pkg::item_t s1;
  s2_t            s2, s2_next;
  mid_t           mid_in, d1_mid;
  tail_t          s4, s4_next, s5, s5_next, s6, s6_next, s7, s7_next;
  fin_t           s8, s8_next, d2_fin;
  logic [NW-1:0]  num2, num2_next;
  logic [W-1:0]   den2, den2_next;
  dct_pkg::div_ctl_t ctl2, ctl2_next;

  logic            d1_valid, d2_valid;
  dct_pkg::sat_t   d1_q, d2_q;
  logic [$bits(mid_t)-1:0] d1_sb;
  logic [$bits(fin_t)-1:0] d2_sb;

  dct_pkg::result_t result_next;
  logic             res_mode;
  logic [1:0]       res_action;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode    <= 1'b0;
      small_threshold <= (W-1)'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dct_pkg::REG_MODE:      combine_mode    <= cfg_data[0];
        dct_pkg::REG_THRESHOLD: small_threshold <= cfg_data[W-2:0];
      endcase
    end
  end

  // front: bad scaling, additive term, raw products, first divider operands
  always_comb begin
    dct_pkg::sat_t add;
    logic          hess;
    s2_next         = '0;
    s2_next.action  = s1.action;
    s2_next.mode    = combine_mode;
    s2_next.bad     = combine_mode &&
                      (dct_pkg::mag(s1.approx_val) < {1'b0, small_threshold} ||
                       (!s1.first_order_check &&
                        dct_pkg::mag(s1.truth_val) < {1'b0, small_threshold}));
    case (s1.action)
      dct_pkg::ACT_VALUE: add = dct_pkg::sat_word(XW'(s1.truth_val) - XW'(s1.approx_val));
      dct_pkg::ACT_GRAD:  add = dct_pkg::sat_word(XW'(s1.truth_grad_row)
                                                  - XW'(s1.approx_grad_row));
      dct_pkg::ACT_HESS:  add = dct_pkg::sat_word(XW'(s1.truth_hess_entry)
                                                  - XW'(s1.approx_hess_entry));
      default:            add = '0;
    endcase
    s2_next.add_r   = add.v;
    s2_next.ovf     = !combine_mode && add.o;
    s2_next.a       = s1.approx_val;
    s2_next.tgr     = s1.truth_grad_row;
    s2_next.agr     = s1.approx_grad_row;
    s2_next.agc     = s1.approx_grad_col;
    s2_next.asq_raw = (2*W)'(s1.approx_val) * (2*W)'(s1.approx_val);
    s2_next.p1_raw  = (2*W)'(s1.truth_hess_entry) * (2*W)'(s1.approx_val);
    s2_next.p2_raw  = (2*W)'(s1.approx_hess_entry) * (2*W)'(s1.truth_val);
    s2_next.p4_raw  = (2*W)'(s1.truth_grad_row) * (2*W)'(s1.approx_grad_col);
    s2_next.p5_raw  = (2*W)'(s1.approx_grad_row) * (2*W)'(s1.truth_grad_col);
    hess            = s1.action == dct_pkg::ACT_HESS;
    s2_next.num     = NW'(dct_pkg::mag(s1.truth_val))
                      << (hess ? dct_pkg::FRAC_BITS + 1 : dct_pkg::FRAC_BITS);
    s2_next.den     = dct_pkg::mag(s1.approx_val);
    s2_next.ctl.neg_n = s1.truth_val[W-1];
    s2_next.ctl.neg_d = s1.approx_val[W-1];
  end

  always_comb begin
    dct_pkg::sat_t asq, p1, p2, p4, p5;
    asq = dct_pkg::scale_q(s2.asq_raw);
    p1  = dct_pkg::scale_q(s2.p1_raw);
    p2  = dct_pkg::scale_q(s2.p2_raw);
    p4  = dct_pkg::scale_q(s2.p4_raw);
    p5  = dct_pkg::scale_q(s2.p5_raw);
    mid_in.action = s2.action;
    mid_in.mode   = s2.mode;
    mid_in.bad    = s2.bad;
    mid_in.ovf    = s2.ovf || (s2.mode && s2.action == dct_pkg::ACT_HESS &&
                               (asq.o || p1.o || p2.o || p4.o || p5.o));
    mid_in.add_r  = s2.add_r;
    mid_in.a      = s2.a;
    mid_in.tgr    = s2.tgr;
    mid_in.agr    = s2.agr;
    mid_in.agc    = s2.agc;
    mid_in.asq    = asq.v;
    mid_in.p1     = p1.v;
    mid_in.p2     = p2.v;
    mid_in.p4     = p4.v;
    mid_in.p5     = p5.v;
  end

  dct_div #(.SB_W($bits(mid_t))) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_num    (s2.num),
    .in_den    (s2.den),
    .in_ctl    (s2.ctl),
    .in_sb     (mid_in),
    .out_valid (d1_valid),
    .out_q     (d1_q),
    .out_sb    (d1_sb)
  );

  assign d1_mid = d1_sb;

  always_comb begin
    s4_next          = '0;
    s4_next.action   = d1_mid.action;
    s4_next.mode     = d1_mid.mode;
    s4_next.bad      = d1_mid.bad;
    s4_next.ovf      = d1_mid.ovf ||
                       (d1_mid.mode && d1_mid.action != dct_pkg::ACT_NONE && d1_q.o);
    s4_next.add_r    = d1_mid.add_r;
    s4_next.ratio    = d1_q.v;
    s4_next.a        = d1_mid.a;
    s4_next.tgr      = d1_mid.tgr;
    s4_next.agc      = d1_mid.agc;
    s4_next.asq      = d1_mid.asq;
    s4_next.p1       = d1_mid.p1;
    s4_next.p2       = d1_mid.p2;
    s4_next.p4       = d1_mid.p4;
    s4_next.p5       = d1_mid.p5;
    s4_next.prod_raw = (2*W)'(d1_mid.agr) * (2*W)'(d1_q.v);
  end

  always_comb begin
    dct_pkg::sat_t m;
    m          = dct_pkg::scale_q(s4.prod_raw);
    s5_next    = s4;
    s5_next.m  = m.v;
    s5_next.ovf = s4.ovf || (s4.mode && m.o &&
                  (s4.action == dct_pkg::ACT_GRAD || s4.action == dct_pkg::ACT_HESS));
  end

  always_comb begin
    dct_pkg::sat_t d;
    d                = dct_pkg::sat_word(XW'(s5.tgr) - XW'(s5.m));
    s6_next          = s5;
    s6_next.diff     = d.v;
    s6_next.prod_raw = (2*W)'(s5.m) * (2*W)'(s5.agc);
    s6_next.ovf      = s5.ovf || (s5.mode && s5.action == dct_pkg::ACT_GRAD && d.o);
  end

  always_comb begin
    dct_pkg::sat_t p3;
    p3          = dct_pkg::scale_q(s6.prod_raw);
    s7_next     = s6;
    s7_next.p3  = p3.v;
    s7_next.ovf = s6.ovf || (s6.mode && s6.action == dct_pkg::ACT_HESS && p3.o);
  end

  // second divider operands: gradient numerator or Hessian sum
  always_comb begin
    dct_pkg::sat_t       sum;
    logic                grad;
    logic signed [W-1:0] n;
    logic signed [W-1:0] d;
    sum  = dct_pkg::sat_word(XW'(s7.p1) - XW'(s7.p2) + XW'(s7.p3)
                             - XW'(s7.p4) - XW'(s7.p5));
    grad = s7.action == dct_pkg::ACT_GRAD;
    n    = grad ? s7.diff : sum.v;
    d    = grad ? s7.a : s7.asq;
    s8_next.action  = s7.action;
    s8_next.mode    = s7.mode;
    s8_next.bad     = s7.bad;
    s8_next.ovf     = s7.ovf || (s7.mode && s7.action == dct_pkg::ACT_HESS && sum.o);
    s8_next.add_r   = s7.add_r;
    s8_next.ratio   = s7.ratio;
    num2_next       = NW'(dct_pkg::mag(n)) << dct_pkg::FRAC_BITS;
    den2_next       = dct_pkg::mag(d);
    ctl2_next.neg_n = n[W-1];
    ctl2_next.neg_d = d[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s4_valid <= d1_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= item;
      s2   <= s2_next;
      s4   <= s4_next;
      s5   <= s5_next;
      s6   <= s6_next;
      s7   <= s7_next;
      s8   <= s8_next;
      num2 <= num2_next;
      den2 <= den2_next;
      ctl2 <= ctl2_next;
    end
  end

  dct_div #(.SB_W($bits(fin_t))) u_div_term (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s8_valid),
    .in_num    (num2),
    .in_den    (den2),
    .in_ctl    (ctl2),
    .in_sb     (s8),
    .out_valid (d2_valid),
    .out_q     (d2_q),
    .out_sb    (d2_sb)
  );

  assign d2_fin = d2_sb;

  always_comb begin
    result_next.scale_warn   = d2_fin.bad;
    result_next.overflow     = d2_fin.ovf;
    result_next.result_value = d2_fin.add_r;
    if (d2_fin.mode) begin
      case (d2_fin.action)
        dct_pkg::ACT_VALUE: result_next.result_value = d2_fin.ratio;
        dct_pkg::ACT_GRAD, dct_pkg::ACT_HESS: begin
          result_next.result_value = d2_q.v;
          result_next.overflow     = d2_fin.ovf || d2_q.o;
        end
        default: result_next.result_value = d2_fin.add_r;
      endcase
    end
    if (d2_fin.action == dct_pkg::ACT_NONE) begin
      result_next.result_value = '0;
      result_next.overflow     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result     <= result_next;
      res_mode   <= d2_fin.mode;
      res_action <= d2_fin.action;
    end
  end

  a_add_no_bad: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !res_mode) |-> !result.scale_warn)
    else $error("bad scaling raised in additive mode");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && res_action == dct_pkg::ACT_NONE) |->
      (result.result_value == '0 && !result.overflow))
    else $error("unused action gave a nonzero term");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> $stable(d2_valid))
    else $error("pipeline moved while stalled");

endmodule

@@ design/dct_div.sv @@
// ----------------------------------------------------------------------------
// dct_div
// Pipelined restoring divider, one quotient bit per stage, signed saturation.
// ----------------------------------------------------------------------------
module dct_div #(
  parameter int SB_W = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [dct_pkg::NUM_W-1:0]      in_num,
  input  logic [dct_pkg::WORD_W-1:0]     in_den,
  input  dct_pkg::div_ctl_t              in_ctl,
  input  logic [SB_W-1:0]                in_sb,
  output logic                           out_valid,
  output dct_pkg::sat_t                  out_q,
  output logic [SB_W-1:0]                out_sb
);

  localparam int W  = dct_pkg::WORD_W;
  localparam int HW = dct_pkg::NUM_W - W;

  logic [W:0]          vld;
  logic [W-1:0]        rem  [0:W];
  logic [W-1:0]        low  [0:W];
  logic [W-1:0]        den  [0:W];
  dct_pkg::div_ctl_t   ctl  [0:W];
  logic                big  [0:W];
  logic                zero [0:W];
  logic [SB_W-1:0]     sb   [0:W];

  logic [HW-1:0]       hi;
  logic [W-1:0]        q;
  logic                neg;
  dct_pkg::sat_t       q_next;

  assign hi = in_num[dct_pkg::NUM_W-1:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[W-1:0], in_valid};
      out_valid <= vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= W'(hi);
      low[0]  <= in_num[W-1:0];
      den[0]  <= in_den;
      ctl[0]  <= in_ctl;
      big[0]  <= {{W{1'b0}}, hi} >= {{HW{1'b0}}, in_den};
      zero[0] <= in_den == '0;
      sb[0]   <= in_sb;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       qb;
    assign trial = {rem[k-1], low[k-1][W-1]};
    assign diff  = trial - {1'b0, den[k-1]};
    assign qb    = ~diff[W];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= qb ? diff[W-1:0] : trial[W-1:0];
        low[k]  <= {low[k-1][W-2:0], qb};
        den[k]  <= den[k-1];
        ctl[k]  <= ctl[k-1];
        big[k]  <= big[k-1];
        zero[k] <= zero[k-1];
        sb[k]   <= sb[k-1];
      end
    end
  end

  always_comb begin
    q        = low[W];
    neg      = ctl[W].neg_n ^ ctl[W].neg_d;
    q_next.o = 1'b0;
    q_next.v = q;
    if (zero[W]) begin
      q_next.o = 1'b1;
      q_next.v = ctl[W].neg_n ? dct_pkg::WORD_MIN : dct_pkg::WORD_MAX;
    end else if (big[W]) begin
      q_next.o = 1'b1;
      q_next.v = neg ? dct_pkg::WORD_MIN : dct_pkg::WORD_MAX;
    end else if (neg) begin
      if (q > dct_pkg::MAG_MIN) begin
        q_next.o = 1'b1;
        q_next.v = dct_pkg::WORD_MIN;
      end else begin
        q_next.v = ~q + 1'b1;
      end
    end else if (q > dct_pkg::MAG_MAX) begin
      q_next.o = 1'b1;
      q_next.v = dct_pkg::WORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q  <= q_next;
      out_sb <= sb[W];
    end
  end

endmodule

@@ tb/sv/discrepancy_correction_term_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// discrepancy_correction_term_chk
// Watches the item, result and register channels, predicts each term from
// the accepted item and the current register values, and compares every
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module discrepancy_correction_term_chk (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  dct_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  dct_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output int               fails,
  output int               pending
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd65536;

  logic             mode_q;
  logic [30:0]      thr_q;
  dct_pkg::result_t expected_terms[$];

  assign pending = expected_terms.size();

  function automatic longint clip(longint v, ref bit o);
    if (v > QMAX) begin
      o = 1;
      return QMAX;
    end
    if (v < QMIN) begin
      o = 1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic longint qmul(longint x, longint y, ref bit o);
    return clip((x * y) / ONE, o);
  endfunction

  function automatic longint qdiv(longint n, longint d, ref bit o);
    if (d == 0) begin
      o = 1;
      return (n >= 0) ? QMAX : QMIN;
    end
    return clip((n * ONE) / d, o);
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic dct_pkg::result_t term_of(dct_pkg::item_t it, logic md,
                                               logic [30:0] th_raw);
    dct_pkg::result_t r;
    bit o;
    bit bad;
    longint t, a, tgr, agr, tgc, agc, th, ah, v, thr;
    longint ratio, prod, diff, asq, p1, p2, r2, p3, p4, p5, num;
    o = 0;
    bad = 0;
    v = 0;
    t = it.truth_val; a = it.approx_val;
    tgr = it.truth_grad_row; agr = it.approx_grad_row;
    tgc = it.truth_grad_col; agc = it.approx_grad_col;
    th = it.truth_hess_entry; ah = it.approx_hess_entry;
    if (!md) begin
      case (it.action)
        dct_pkg::ACT_VALUE: v = clip(t - a, o);
        dct_pkg::ACT_GRAD:  v = clip(tgr - agr, o);
        dct_pkg::ACT_HESS:  v = clip(th - ah, o);
        default:            v = 0;
      endcase
    end else begin
      thr = th_raw;
      bad = absv(a) < thr || (!it.first_order_check && absv(t) < thr);
      case (it.action)
        dct_pkg::ACT_VALUE: v = qdiv(t, a, o);
        dct_pkg::ACT_GRAD: begin
          ratio = qdiv(t, a, o);
          prod = qmul(agr, ratio, o);
          diff = clip(tgr - prod, o);
          v = qdiv(diff, a, o);
        end
        dct_pkg::ACT_HESS: begin
          asq = qmul(a, a, o);
          p1 = qmul(th, a, o);
          p2 = qmul(ah, t, o);
          if (a == 0) begin
            o = 1;
            r2 = (t >= 0) ? QMAX : QMIN;
          end else begin
            r2 = clip((t * 2 * ONE) / a, o);
          end
          p3 = qmul(qmul(r2, agr, o), agc, o);
          p4 = qmul(tgr, agc, o);
          p5 = qmul(agr, tgc, o);
          num = clip(p1 - p2 + p3 - p4 - p5, o);
          v = qdiv(num, asq, o);
        end
        default: v = 0;
      endcase
    end
    if (it.action == dct_pkg::ACT_NONE) begin
      v = 0;
      o = 0;
    end
    r.result_value = v[31:0];
    r.scale_warn = bad;
    r.overflow = o;
    return r;
  endfunction

  always @(posedge clk) begin
    dct_pkg::result_t e;
    if (rst) begin
      mode_q <= 1'b0;
      thr_q <= 31'd1;
      fails <= 0;
      expected_terms.delete();
    end else begin
      if (item_valid && !item_stall)
        expected_terms.push_back(term_of(item, mode_q, thr_q));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dct_pkg::REG_MODE) mode_q <= cfg_data[0];
        else thr_q <= cfg_data[30:0];
      end
      if (result_valid && !result_stall) begin
        if (expected_terms.size() == 0) begin
          if (fails < 10) $display("unexpected result beat %h", result);
          fails <= fails + 1;
        end else begin
          e = expected_terms.pop_front();
          if (e !== result) begin
            if (fails < 10)
              $display("mismatch: exp val %h bad %b ovf %b, got val %h bad %b ovf %b",
                       e.result_value, e.scale_warn, e.overflow,
                       result.result_value, result.scale_warn, result.overflow);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/discrepancy_correction_term_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// discrepancy_correction_term_tb
// Drives directed and random items through the block under both combine
// modes and several thresholds, with random idling on both sides and one
// long result hold-off; the checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module discrepancy_correction_term_tb;

  logic    clk = 0;
  logic    rst = 1;
  logic    item_valid = 0;
  logic    item_stall;
  dct_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 0;
  dct_pkg::result_t result;
  logic    cfg_valid = 0;
  logic    cfg_ready;
  logic    cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int      fails;
  int      pending;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_cycles = 0;
  bit      hold_req = 0;
  bit      hold_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  discrepancy_correction_term i_dut (.*);

  discrepancy_correction_term_chk i_chk (.*);

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      result_stall <= 1'b1;
      hold_cycles <= 300;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(3) << 16;
      4: return 32'($signed($urandom_range(511)) - 256);
      5: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(dct_pkg::item_t it);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic dct_pkg::item_t rand_term();
    dct_pkg::item_t it;
    it.action = ($urandom_range(15) == 0) ? dct_pkg::ACT_NONE : 2'($urandom_range(2));
    it.first_order_check = 1'($urandom_range(1));
    it.truth_val = pick_word();
    it.approx_val = pick_word();
    it.truth_grad_row = pick_word();
    it.approx_grad_row = pick_word();
    it.truth_grad_col = pick_word();
    it.approx_grad_col = pick_word();
    it.truth_hess_entry = pick_word();
    it.approx_hess_entry = pick_word();
    return it;
  endfunction

  initial begin
    dct_pkg::item_t it;
    logic [31:0] thr_set[4] = '{32'd1, 32'd0, 32'h7fffffff, 32'h00010000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int m = 0; m < 2; m++) begin
      write_reg(dct_pkg::REG_MODE, 32'(m));
      for (int k = 0; k < 12; k++) begin
        it = '0;
        it.action = 2'(k % 4);
        it.first_order_check = k[2];
        it.truth_val = (k < 4) ? 32'h7fffffff : (k < 8 ? 32'h80000000 : 32'h00020000);
        it.approx_val = (k < 4) ? 32'h80000000 : (k < 8 ? 32'h0 : 32'h00000001);
        it.truth_grad_row = 32'h7fffffff;
        it.approx_grad_row = 32'h80000000;
        it.truth_grad_col = 32'h00010000;
        it.approx_grad_col = 32'hffff0000;
        it.truth_hess_entry = 32'h80000000;
        it.approx_hess_entry = 32'h7fffffff;
        send_item(it);
      end
      drain();
    end
    for (int p = 0; p < 8; p++) begin
      write_reg(dct_pkg::REG_MODE, 32'(p % 2));
      write_reg(dct_pkg::REG_THRESHOLD, thr_set[p % 4] | ($urandom_range(1) << 31));
      send_idle = (p < 3) ? 12 : (p < 6 ? 82 : 0);
      recv_idle = (p < 3) ? 82 : (p < 6 ? 12 : 0);
      if (p == 6) hold_req = 1'b1;
      for (int n = 0; n < 90; n++) send_item(rand_term());
      drain();
    end
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
